// ===== sv/frustum_cull_test_macros.svh =====
// Assertion macros shared by the frustum culling unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef FRUSTUM_CULL_TEST_MACROS_SVH
`define FRUSTUM_CULL_TEST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in next-cycle check");

`endif

// ===== sv/fct_pkg.sv =====
// Package for the frustum culling unit: sizes, codes and the queued item type.
// No dependencies.
`default_nettype none
package fct_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int CORNER_COUNT = 8;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS = 16;

  localparam int SIZE_WIDTH = COORD_WIDTH - 1;
  localparam int EXT_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = COORD_WIDTH + EXT_WIDTH;
  localparam int SUM_WIDTH = PROD_WIDTH + 3;
  localparam int OP_WIDTH = 3;
  localparam int SLOT_WIDTH = 3;
  localparam int VERDICT_WIDTH = 2;
  localparam int PLANE_IDX_WIDTH = $clog2(PLANE_COUNT);
  localparam int CORNER_IDX_WIDTH = $clog2(CORNER_COUNT);
  localparam int STEP_WIDTH = $clog2(CORNER_COUNT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);

  typedef enum logic [OP_WIDTH-1:0] {
    OP_LOAD_PLANE  = 3'd0,
    OP_LOAD_CORNER = 3'd1,
    OP_TEST_POINT  = 3'd2,
    OP_TEST_SPHERE = 3'd3,
    OP_TEST_BOX    = 3'd4
  } op_e;

  typedef enum logic [VERDICT_WIDTH-1:0] {
    VERDICT_ACK     = 2'd0,
    VERDICT_OUTSIDE = 2'd1,
    VERDICT_INSIDE  = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_PLANE,
    KIND_CORNER,
    KIND_SPHERE,
    KIND_BOX
  } kind_e;

  typedef struct packed {
    kind_e                         kind;
    logic [SLOT_WIDTH-1:0]         slot;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [COORD_WIDTH-1:0] offset;
    logic [SIZE_WIDTH-1:0]         size;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/fct_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
// Depends on fct_pkg.
`default_nettype none
module fct_front import fct_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [OP_WIDTH-1:0]           operation_i,
  input  wire logic [SLOT_WIDTH-1:0]         slot_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] plane_offset_i,
  input  wire logic [SIZE_WIDTH-1:0]         size_value_i,
  output logic                               pop_valid_o,
  input  wire logic                          pop_ready_i,
  output item_t                              item_o
);

  item_t                 entry_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_WIDTH:0]   count_q;
  item_t                 cls;
  logic                  push, pop;

  always_comb begin
    cls.slot   = slot_i;
    cls.x      = coord_x_i;
    cls.y      = coord_y_i;
    cls.z      = coord_z_i;
    cls.offset = plane_offset_i;
    cls.size   = size_value_i;
    cls.kind   = KIND_NOP;
    case (operation_i)
      OP_LOAD_PLANE: begin
        if ({1'b0, slot_i} < (SLOT_WIDTH + 1)'(PLANE_COUNT)) begin
          cls.kind = KIND_PLANE;
        end
      end
      OP_LOAD_CORNER: cls.kind = KIND_CORNER;
      OP_TEST_POINT: begin
        cls.kind = KIND_SPHERE;
        cls.size = '0;
      end
      OP_TEST_SPHERE: cls.kind = KIND_SPHERE;
      OP_TEST_BOX:    cls.kind = KIND_BOX;
      default:        cls.kind = KIND_NOP;
    endcase
  end

  assign in_ready_o  = count_q != (QPTR_WIDTH + 1)'(QUEUE_DEPTH);
  assign pop_valid_o = count_q != '0;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = pop_valid_o & pop_ready_i;
  assign item_o      = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= cls;
  end

endmodule
`default_nettype wire

// ===== sv/fct_back.sv =====
// Back end: holds the plane and corner tables and runs the tests step by step over planes and corners.
// Depends on fct_pkg.
`default_nettype none
module fct_back import fct_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  output logic                          item_ready_o,
  input  wire item_t                    item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [VERDICT_WIDTH-1:0]      verdict_o
);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  logic signed [COORD_WIDTH-1:0] nx_q [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0] ny_q [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0] nz_q [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0] off_tab_q [PLANE_COUNT];
  logic signed [COORD_WIDTH-1:0] cx_q [CORNER_COUNT];
  logic signed [COORD_WIDTH-1:0] cy_q [CORNER_COUNT];
  logic signed [COORD_WIDTH-1:0] cz_q [CORNER_COUNT];

  state_e                        state_q;
  item_t                         job_q;
  logic [STEP_WIDTH-1:0]         step_q;
  logic                          pv_q, plane_out_q, out_valid_q;
  logic [5:0]                    beyond_q;
  verdict_e                      verdict_q;
  logic signed [PROD_WIDTH-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [PROD_WIDTH-1:0]  prod_x_d, prod_y_d, prod_z_d;
  logic signed [COORD_WIDTH-1:0] off_q;

  logic                          take, is_box, plane_step, corner_step, neg_now, outside;
  logic [PLANE_IDX_WIDTH-1:0]    pidx;
  logic [CORNER_IDX_WIDTH-1:0]   cidx;
  logic signed [EXT_WIDTH-1:0]   xe, ye, ze, he, hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;
  logic signed [EXT_WIDTH-1:0]   vx, vy, vz, cxe, cye, cze;
  logic signed [COORD_WIDTH-1:0] nxs, nys, nzs;
  logic signed [SUM_WIDTH-1:0]   sum_d, sub_w;
  logic [5:0]                    b_now;

  assign item_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign take         = item_valid_i & item_ready_o;
  assign is_box       = job_q.kind == KIND_BOX;
  assign plane_step   = step_q < STEP_WIDTH'(PLANE_COUNT);
  assign corner_step  = step_q < STEP_WIDTH'(CORNER_COUNT);
  assign pidx         = step_q[PLANE_IDX_WIDTH-1:0];
  assign cidx         = step_q[CORNER_IDX_WIDTH-1:0];

  always_comb begin
    xe   = EXT_WIDTH'(job_q.x);
    ye   = EXT_WIDTH'(job_q.y);
    ze   = EXT_WIDTH'(job_q.z);
    he   = $signed({2'b00, job_q.size});
    hi_x = xe + he;
    lo_x = xe - he;
    hi_y = ye + he;
    lo_y = ye - he;
    hi_z = ze + he;
    lo_z = ze - he;
    nxs  = nx_q[pidx];
    nys  = ny_q[pidx];
    nzs  = nz_q[pidx];
    // For a box the corner farthest along the normal decides whether all corners are behind.
    vx   = is_box ? (nxs[COORD_WIDTH-1] ? lo_x : hi_x) : xe;
    vy   = is_box ? (nys[COORD_WIDTH-1] ? lo_y : hi_y) : ye;
    vz   = is_box ? (nzs[COORD_WIDTH-1] ? lo_z : hi_z) : ze;
    prod_x_d = PROD_WIDTH'(nxs) * PROD_WIDTH'(vx);
    prod_y_d = PROD_WIDTH'(nys) * PROD_WIDTH'(vy);
    prod_z_d = PROD_WIDTH'(nzs) * PROD_WIDTH'(vz);
    sub_w = is_box ? '0 : $signed(SUM_WIDTH'(job_q.size));
    sum_d = SUM_WIDTH'(prod_x_q) + SUM_WIDTH'(prod_y_q) + SUM_WIDTH'(prod_z_q)
          + (SUM_WIDTH'(off_q) <<< FRAC_BITS) - (sub_w <<< FRAC_BITS);
    neg_now = sum_d[SUM_WIDTH-1];
    cxe = EXT_WIDTH'(cx_q[cidx]);
    cye = EXT_WIDTH'(cy_q[cidx]);
    cze = EXT_WIDTH'(cz_q[cidx]);
    b_now = {cze < lo_z, cze > hi_z, cye < lo_y, cye > hi_y, cxe < lo_x, cxe > hi_x};
    outside = plane_out_q | (pv_q & neg_now) | (is_box & (|beyond_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      pv_q        <= 1'b0;
      plane_out_q <= 1'b0;
      beyond_q    <= '0;
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_ACK;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (item_i.kind == KIND_SPHERE || item_i.kind == KIND_BOX) begin
              state_q     <= S_RUN;
              step_q      <= '0;
              pv_q        <= 1'b0;
              plane_out_q <= 1'b0;
              beyond_q    <= '1;
            end else begin
              out_valid_q <= 1'b1;
              verdict_q   <= VERDICT_ACK;
            end
          end
        end
        S_RUN: begin
          step_q <= step_q + 1'b1;
          pv_q   <= plane_step;
          if (pv_q && neg_now) plane_out_q <= 1'b1;
          if (corner_step) beyond_q <= beyond_q & b_now;
          if (step_q == STEP_WIDTH'(CORNER_COUNT)) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            verdict_q   <= outside ? VERDICT_OUTSIDE : VERDICT_INSIDE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= item_i;
    if (state_q == S_RUN) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      off_q    <= off_tab_q[pidx];
    end
    if (take && item_i.kind == KIND_PLANE) begin
      nx_q[item_i.slot[PLANE_IDX_WIDTH-1:0]]      <= item_i.x;
      ny_q[item_i.slot[PLANE_IDX_WIDTH-1:0]]      <= item_i.y;
      nz_q[item_i.slot[PLANE_IDX_WIDTH-1:0]]      <= item_i.z;
      off_tab_q[item_i.slot[PLANE_IDX_WIDTH-1:0]] <= item_i.offset;
    end
    if (take && item_i.kind == KIND_CORNER) begin
      cx_q[item_i.slot[CORNER_IDX_WIDTH-1:0]] <= item_i.x;
      cy_q[item_i.slot[CORNER_IDX_WIDTH-1:0]] <= item_i.y;
      cz_q[item_i.slot[CORNER_IDX_WIDTH-1:0]] <= item_i.z;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule
`default_nettype wire

// ===== sv/frustum_cull_test.sv =====
// Frustum culling unit: transactions are queued in the front end; the back end acknowledges
// a load transaction in the cycle after it takes it. Point, sphere and box tests run under
// the back-end step counter that walks planes and corners with three multipliers, and the
// back end takes no new transaction until a test's verdict is given, though the front-end
// queue can still accept transactions while it has room. Reset clears control state only;
// plane and corner tables are undefined until loaded.
`default_nettype none
`include "frustum_cull_test_macros.svh"
module frustum_cull_test import fct_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [OP_WIDTH-1:0]           operation_i,
  input  wire logic [SLOT_WIDTH-1:0]         slot_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] plane_offset_i,
  input  wire logic [SIZE_WIDTH-1:0]         size_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [VERDICT_WIDTH-1:0]           verdict_o
);

  logic  q_valid, bk_ready, bk_take;
  item_t q_item;

  fct_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .slot_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .plane_offset_i, .size_value_i,
    .pop_valid_o (q_valid),
    .pop_ready_i (bk_ready),
    .item_o      (q_item)
  );

  fct_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i (q_valid),
    .item_ready_o (bk_ready),
    .item_i       (q_item),
    .out_valid_o, .out_ready_i, .verdict_o
  );

  assign bk_take = q_valid & bk_ready;

  `FCT_ASSERT_SAME(a_result_slot_free, bk_ready, !out_valid_o || out_ready_i)
  `FCT_ASSERT_NEXT(a_load_ack, bk_take && (q_item.kind == KIND_PLANE || q_item.kind == KIND_CORNER), out_valid_o && verdict_o == VERDICT_ACK)
  `FCT_ASSERT_NEXT(a_test_busy, bk_take && (q_item.kind == KIND_SPHERE || q_item.kind == KIND_BOX), !bk_ready && !out_valid_o)

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the frustum culling unit: random and directed load and test transactions
// checked against a scoreboard class that predicts each verdict. Depends on fct_pkg and on
// frustum_cull_test.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import fct_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 560;
  localparam logic [OP_WIDTH-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_UNUSED_LAST = 3'd7;
  localparam int ONE = 65536;
  localparam int HALF_SPAN = 100 * ONE;

  class verdict_tracker;
    longint nx[PLANE_COUNT], ny[PLANE_COUNT], nz[PLANE_COUNT], noff[PLANE_COUNT];
    longint cx[CORNER_COUNT], cy[CORNER_COUNT], cz[CORNER_COUNT];
    verdict_e expected_q[$];
    int mismatches = 0;

    function automatic bit behind(int i, longint px, longint py, longint pz, longint sz);
      logic signed [127:0] a, b, acc, t;
      a = nx[i]; b = px; acc = a * b;
      a = ny[i]; b = py; acc = acc + a * b;
      a = nz[i]; b = pz; acc = acc + a * b;
      t = noff[i]; acc = acc + (t <<< FRAC_BITS);
      t = sz; acc = acc - (t <<< FRAC_BITS);
      return acc[127];
    endfunction

    function automatic verdict_e classify_sphere(longint x, longint y, longint z, longint r);
      for (int i = 0; i < PLANE_COUNT; i++) if (behind(i, x, y, z, r)) return VERDICT_OUTSIDE;
      return VERDICT_INSIDE;
    endfunction

    function automatic verdict_e classify_box(longint x, longint y, longint z, longint h);
      int n[6];
      for (int i = 0; i < PLANE_COUNT; i++) begin
        int cnt;
        cnt = 0;
        for (int c = 0; c < 8; c++) begin
          if (behind(i, c[0] ? x - h : x + h, c[1] ? y - h : y + h, c[2] ? z - h : z + h, 0))
            cnt++;
        end
        if (cnt == 8) return VERDICT_OUTSIDE;
      end
      n = '{0, 0, 0, 0, 0, 0};
      for (int k = 0; k < CORNER_COUNT; k++) begin
        if (cx[k] > x + h) n[0]++;
        if (cx[k] < x - h) n[1]++;
        if (cy[k] > y + h) n[2]++;
        if (cy[k] < y - h) n[3]++;
        if (cz[k] > z + h) n[4]++;
        if (cz[k] < z - h) n[5]++;
      end
      foreach (n[j]) if (n[j] == CORNER_COUNT) return VERDICT_OUTSIDE;
      return VERDICT_INSIDE;
    endfunction

    function automatic void note_input(logic [OP_WIDTH-1:0] op, logic [SLOT_WIDTH-1:0] sl,
                                       logic signed [COORD_WIDTH-1:0] x, y, z, d,
                                       logic [SIZE_WIDTH-1:0] s);
      verdict_e v;
      longint sz;
      v = VERDICT_ACK;
      sz = s;
      case (op)
        OP_LOAD_PLANE: if (sl < PLANE_COUNT) begin
          nx[sl] = x; ny[sl] = y; nz[sl] = z; noff[sl] = d;
        end
        OP_LOAD_CORNER: begin
          cx[sl] = x; cy[sl] = y; cz[sl] = z;
        end
        OP_TEST_POINT: v = classify_sphere(x, y, z, 0);
        OP_TEST_SPHERE: v = classify_sphere(x, y, z, sz);
        OP_TEST_BOX: v = classify_box(x, y, z, sz);
        default: v = VERDICT_ACK;
      endcase
      expected_q.insert(expected_q.size(), v);
    endfunction

    function automatic void check_result(logic [VERDICT_WIDTH-1:0] got);
      verdict_e want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: verdict %0d", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Verdict mismatch: expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_WIDTH-1:0] op = '0;
  logic [SLOT_WIDTH-1:0] slot = '0;
  logic signed [COORD_WIDTH-1:0] cx_in = '0, cy_in = '0, cz_in = '0, off_in = '0;
  logic [SIZE_WIDTH-1:0] size_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VERDICT_WIDTH-1:0] verdict;

  verdict_tracker sb = new;
  int cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int hold_cnt = 0;
  bit held = 1'b0;

  always #5 clk = ~clk;

  frustum_cull_test uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .slot_i(slot),
    .coord_x_i(cx_in), .coord_y_i(cy_in), .coord_z_i(cz_in),
    .plane_offset_i(off_in), .size_value_i(size_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .verdict_o(verdict)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(op, slot, cx_in, cy_in, cz_in, off_in, size_in);
    if (rst_n && out_valid && out_ready) sb.check_result(verdict);
  end

  // The receiver cycles through stall patterns and holds off once for a long stretch.
  always @(posedge clk) begin
    if (!held && items_sent >= 300) begin
      held = 1'b1;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      case ((cycles / 97) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycles % 3 != 0);
      endcase
    end
  end

  task automatic send_item(logic [OP_WIDTH-1:0] o, logic [SLOT_WIDTH-1:0] sl,
                           logic signed [COORD_WIDTH-1:0] x, y, z, d,
                           logic [SIZE_WIDTH-1:0] s);
    in_valid <= 1'b1;
    op <= o; slot <= sl; cx_in <= x; cy_in <= y; cz_in <= z; off_in <= d; size_in <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic load_cube_frustum();
    send_item(OP_LOAD_PLANE, 0, ONE, 0, 0, HALF_SPAN, 0);
    send_item(OP_LOAD_PLANE, 1, -ONE, 0, 0, HALF_SPAN, 0);
    send_item(OP_LOAD_PLANE, 2, 0, ONE, 0, HALF_SPAN, 0);
    send_item(OP_LOAD_PLANE, 3, 0, -ONE, 0, HALF_SPAN, 0);
    send_item(OP_LOAD_PLANE, 4, 0, 0, ONE, HALF_SPAN, 0);
    send_item(OP_LOAD_PLANE, 5, 0, 0, -ONE, HALF_SPAN, 0);
    for (int k = 0; k < CORNER_COUNT; k++) begin
      send_item(OP_LOAD_CORNER, SLOT_WIDTH'(k), k[0] ? HALF_SPAN : -HALF_SPAN,
                k[1] ? HALF_SPAN : -HALF_SPAN, k[2] ? HALF_SPAN : -HALF_SPAN, 0, 0);
    end
  endtask

  function automatic int small_coord();
    return $signed($urandom_range(0, 600 * ONE)) - 300 * ONE;
  endfunction

  initial begin
    int r;
    logic signed [COORD_WIDTH-1:0] x, y, z, d;
    logic [SIZE_WIDTH-1:0] s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_cube_frustum();
    send_item(OP_TEST_POINT, 0, 0, 0, 0, 0, 0);
    send_item(OP_TEST_POINT, 7, -HALF_SPAN, HALF_SPAN, 0, 0, 31'h7fffffff);
    send_item(OP_TEST_POINT, 0, HALF_SPAN + 1, 0, 0, 0, 0);
    send_item(OP_TEST_POINT, 0, 32'sh80000000, 32'sh7fffffff, 0, 0, 0);
    send_item(OP_TEST_SPHERE, 0, 150 * ONE, 0, 0, 0, 50 * ONE);
    send_item(OP_TEST_SPHERE, 0, 150 * ONE, 0, 0, 0, 50 * ONE - 1);
    send_item(OP_TEST_SPHERE, 0, 0, 0, 0, 0, 31'h7fffffff);
    send_item(OP_TEST_BOX, 0, 0, 0, 0, 0, 0);
    send_item(OP_TEST_BOX, 0, 180 * ONE, 180 * ONE, 0, 0, 70 * ONE);
    send_item(OP_TEST_BOX, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 31'h7fffffff);
    send_item(OP_LOAD_PLANE, 6, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_item(OP_LOAD_PLANE, 7, -1, -1, -1, -1, 31'h7fffffff);
    send_item(OP_UNUSED_FIRST, 3, -1, -1, -1, -1, 31'h7fffffff);
    send_item(OP_UNUSED_LAST, 0, 0, 0, 0, 0, 0);
    send_item(OP_TEST_POINT, 0, 0, 0, 0, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 119) load_cube_frustum();
      if (n == 450) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (sb.expected_q.size() == 0);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) begin
        x = $urandom; y = $urandom; z = $urandom; d = $urandom; s = SIZE_WIDTH'($urandom);
      end else begin
        x = small_coord(); y = small_coord(); z = small_coord(); d = small_coord();
        s = SIZE_WIDTH'($urandom_range(0, 150 * ONE));
      end
      if (r < 6) begin
        if ($urandom_range(0, 1) == 0) begin
          x = x / 150; y = y / 150; z = z / 150;
        end
        send_item(OP_LOAD_PLANE, SLOT_WIDTH'($urandom_range(0, 7)), x, y, z, d, s);
      end else if (r < 12) begin
        send_item(OP_LOAD_CORNER, SLOT_WIDTH'($urandom_range(0, 7)), x, y, z, d, s);
      end else if (r < 15) begin
        send_item(OP_WIDTH'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                  SLOT_WIDTH'($urandom), x, y, z, d, s);
      end else begin
        send_item(OP_WIDTH'($urandom_range(OP_TEST_POINT, OP_TEST_BOX)),
                  SLOT_WIDTH'($urandom), x, y, z, d, s);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    wait (sb.expected_q.size() == 0);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/fct_pkg.sv
sv/fct_front.sv
sv/fct_back.sv
sv/frustum_cull_test.sv
sim/testbench.sv
